### hw/rtl/cartridge_bank_mapper_macros.svh
// assertion macros shared by the cartridge bank mapper rtl
`ifndef CARTRIDGE_BANK_MAPPER_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_MACROS_SVH

// same-cycle implication, checked outside reset
`define CBM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define CBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/cbm_pkg.sv
// types and constants of the cartridge bank mapper
package cbm_pkg;

  // cartridge ram and rom geometry
  localparam int RAM_BYTES     = 32768;
  localparam int RAM_AW        = $clog2(RAM_BYTES);
  localparam int ROM_BANK_BITS = 7;
  localparam int ROM_AW        = 21;

  // result queue behind the ram read stage
  localparam int RSP_DEPTH = 3;
  localparam int RSP_PW    = $clog2(RSP_DEPTH);
  localparam int RSP_CW    = $clog2(RSP_DEPTH + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_CART_TYPE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_SIZE  = CFG_IDX_W'(1);

  // access kinds
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // bus constants
  localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
  localparam logic [7:0] OPEN_BUS       = 8'hFF;

  // register write windows and the cartridge ram window, address bits 15:13
  localparam logic [2:0] WIN_RAM_ENABLE = 3'b000;
  localparam logic [2:0] WIN_ROM_BANK   = 3'b001;
  localparam logic [2:0] WIN_RAM_BANK   = 3'b010;
  localparam logic [2:0] WIN_BANK_MODE  = 3'b011;
  localparam logic [2:0] WIN_CART_RAM   = 3'b101;

  typedef struct packed {
    logic        func;
    logic [15:0] address;
    logic [7:0]  value;
  } req_word_t;

  typedef struct packed {
    logic [7:0]        read_data;
    logic              rom_read;
    logic [ROM_AW-1:0] rom_address;
    logic              flush_request;
  } rsp_word_t;

endpackage

### hw/rtl/cbm_ram.sv
// generic single-port ram with registered read
module cbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write or registered read, one port
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

### hw/rtl/cartridge_bank_mapper.sv
// MBC1 / MBC3 style cartridge bank controller top level
//
// Bus accesses arrive on req (req_valid / req_ready), one word each, and
// every access gives exactly one word on rsp (rsp_valid / rsp_ready). Writes
// below 0x8000 set RAM enable, ROM bank, RAM bank and banking mode; ROM reads
// return the mapped, size-wrapped physical ROM byte address; 0xA000-0xBFFF
// goes to the internal cartridge RAM while it is enabled.
// cfg (cfg_valid / cfg_ready) writes cart_type (index 0) and rom_size_log2
// (index 1); it is always ready and should be used only while idle.
// An accepted access goes through the read stage and the result queue before
// rsp_valid. One access is taken every cycle while req_ready is high, bounded
// by the RAM's single port, which each enabled RAM access uses once in the accept cycle.
// After reset the RAM is cleared one byte per cycle, all 32768 bytes, with
// req_ready low; cfg writes are taken during that time.
// A three-word result queue sits behind the RAM read stage, so req_ready is
// a register function: when rsp_ready stays low the queue fills and
// req_ready drops; nothing is dropped or repeated.
`include "cartridge_bank_mapper_macros.svh"

module cartridge_bank_mapper (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  cbm_pkg::req_word_t               req,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output cbm_pkg::rsp_word_t               rsp,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cbm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [7:0]                       cfg_data
);
  import cbm_pkg::*;

  // configuration and controller registers
  logic [7:0]               cart_type;
  logic [4:0]               rom_size_log2;
  logic [ROM_BANK_BITS-1:0] rom_bank_reg;
  logic [ROM_BANK_BITS-1:0] rom_bank_next;
  logic [1:0]               ram_bank_reg;
  logic [1:0]               ram_bank_next;
  logic                     ram_on;
  logic                     ram_on_next;
  logic                     bank_mode;
  logic                     bank_mode_next;

  // clearing pass
  logic              clr_busy;
  logic [RAM_AW-1:0] clr_addr;

  // decode
  logic                     accept;
  logic                     mbc1;
  logic                     mbc3;
  logic                     in_ram;
  logic                     ram_enable;
  logic [14:0]              ram_full;
  logic [4:0]               rom_lg;
  logic [ROM_AW-1:0]        rom_mask;
  logic [ROM_BANK_BITS-1:0] bank_sel;
  logic [ROM_AW-1:0]        rom_lin;
  logic [4:0]               lo5;
  logic [6:0]               lo7;
  logic [7:0]               bank_tmp;
  rsp_word_t                s0_word;
  logic                     s0_ram_rd;

  // ram port
  logic              ram_en;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_addr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;

  // read stage and result queue
  logic              s1_valid;
  logic              s1_ram_rd;
  rsp_word_t         s1_word;
  rsp_word_t         push_word;
  rsp_word_t         rsp_mem [RSP_DEPTH];
  logic [RSP_PW-1:0] wr_ptr;
  logic [RSP_PW-1:0] rd_ptr;
  logic [RSP_CW-1:0] fifo_count;
  logic              pop;

  assign accept    = req_valid && req_ready;
  assign cfg_ready = 1'b1;
  assign mbc1      = (cart_type >= 8'h01) && (cart_type <= 8'h03);
  assign mbc3      = (cart_type >= 8'h0F) && (cart_type <= 8'h13);
  assign in_ram    = (req.address[15:13] == WIN_CART_RAM);
  assign ram_enable = (req.value[3:0] == RAM_ENABLE_KEY);

  // ram byte index, bank above the 8 KiB window offset
  assign ram_full = {ram_bank_reg, req.address[12:0]};

  // rom address, bank zero below 0x4000, wrapped to the rom size
  assign rom_lg   = (rom_size_log2 > 5'(ROM_AW)) ? 5'(ROM_AW) : rom_size_log2;
  assign bank_sel = req.address[14] ? rom_bank_reg : '0;
  assign rom_lin  = ROM_AW'({bank_sel, req.address[13:0]});

  always_comb begin
    for (int i = 0; i < ROM_AW; i++) begin
      rom_mask[i] = (5'(i) < rom_lg);
    end
  end

  // result fields known at accept time
  always_comb begin
    s0_word   = '0;
    s0_ram_rd = 1'b0;
    if (req.func == FUNC_READ) begin
      if (!req.address[15]) begin
        s0_word.rom_read    = 1'b1;
        s0_word.rom_address = rom_lin & rom_mask;
      end else if (in_ram && ram_on) begin
        s0_ram_rd = 1'b1;
      end else begin
        s0_word.read_data = OPEN_BUS;
      end
    end else begin
      s0_word.flush_request = (req.address[15:13] == WIN_RAM_ENABLE) && ram_on && !ram_enable;
    end
  end

  // controller register writes
  always_comb begin
    rom_bank_next  = rom_bank_reg;
    ram_bank_next  = ram_bank_reg;
    ram_on_next    = ram_on;
    bank_mode_next = bank_mode;
    lo5      = (req.value[4:0] == 5'd0) ? 5'd1 : req.value[4:0];
    lo7      = (req.value[6:0] == 7'd0) ? 7'd1 : req.value[6:0];
    bank_tmp = '0;
    if (accept && req.func == FUNC_WRITE) begin
      unique case (req.address[15:13])
        WIN_RAM_ENABLE: begin
          ram_on_next = ram_enable;
        end
        WIN_ROM_BANK: begin
          if (mbc1) begin
            bank_tmp      = (8'(rom_bank_reg) & 8'hE0) | {3'b000, lo5};
            rom_bank_next = bank_tmp[ROM_BANK_BITS-1:0];
          end else if (mbc3) begin
            rom_bank_next = lo7[ROM_BANK_BITS-1:0];
          end
        end
        WIN_RAM_BANK: begin
          if (mbc1) begin
            if (bank_mode) begin
              ram_bank_next = req.value[1:0];
            end else begin
              bank_tmp      = (8'(rom_bank_reg) & 8'h1F) | {1'b0, req.value[1:0], 5'b00000};
              rom_bank_next = bank_tmp[ROM_BANK_BITS-1:0];
            end
          end else if (mbc3) begin
            if (req.value <= 8'h03) begin
              ram_bank_next = req.value[1:0];
            end
          end
        end
        WIN_BANK_MODE: begin
          if (mbc1) begin
            bank_mode_next = req.value[0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank_reg <= ROM_BANK_BITS'(1);
      ram_bank_reg <= '0;
      ram_on       <= 1'b0;
      bank_mode    <= 1'b0;
    end else begin
      rom_bank_reg <= rom_bank_next;
      ram_bank_reg <= ram_bank_next;
      ram_on       <= ram_on_next;
      bank_mode    <= bank_mode_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cart_type     <= 8'd0;
      rom_size_log2 <= 5'(ROM_AW);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CART_TYPE: cart_type <= cfg_data;
        CFG_ROM_SIZE:  rom_size_log2 <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  // ram clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + RAM_AW'(1);
      if (clr_addr == {RAM_AW{1'b1}}) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // ram port: clearing pass or the accepted access
  assign ram_en    = clr_busy || (accept && in_ram && ram_on);
  assign ram_we    = clr_busy || (req.func == FUNC_WRITE);
  assign ram_addr  = clr_busy ? clr_addr : ram_full[RAM_AW-1:0];
  assign ram_wdata = clr_busy ? 8'd0 : req.value;

  cbm_ram #(
    .WIDTH (8),
    .DEPTH (RAM_BYTES)
  ) u_cart_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // read stage waits for the ram data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word   <= s0_word;
      s1_ram_rd <= s0_ram_rd;
    end
  end

  always_comb begin
    push_word = s1_word;
    if (s1_ram_rd) begin
      push_word.read_data = ram_rdata;
    end
  end

  // result queue, read stage always drains into it
  assign pop       = rsp_valid && rsp_ready;
  assign rsp_valid = (fifo_count != '0);
  assign rsp       = rsp_mem[rd_ptr];
  assign req_ready = !clr_busy &&
                     ((3'(fifo_count) + 3'(s1_valid)) < 3'(RSP_DEPTH));

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      rsp_mem[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (s1_valid) begin
        wr_ptr <= (wr_ptr == RSP_PW'(RSP_DEPTH - 1)) ? '0 : wr_ptr + RSP_PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == RSP_PW'(RSP_DEPTH - 1)) ? '0 : rd_ptr + RSP_PW'(1);
      end
      fifo_count <= fifo_count + RSP_CW'(s1_valid) - RSP_CW'(pop);
    end
  end

  // checks
  `CBM_ASSERT_NOW(a_no_req_in_clear, clr_busy, !req_ready, "access taken during ram clear")
  `CBM_ASSERT_NOW(a_rsp_room, s1_valid, fifo_count != RSP_CW'(RSP_DEPTH), "result queue overflow")
  `CBM_ASSERT_NEXT(a_ram_read_tracked, accept && s0_ram_rd, s1_valid && s1_ram_rd, "ram read lost")
  `CBM_ASSERT_NEXT(a_flush_turns_off, accept && s0_word.flush_request, !ram_on, "flush with ram on")

endmodule

### bench/cartridge_bank_mapper_tb.sv
// self-checking bench for the cartridge bank mapper: predicted bus results under random flow control
`timescale 1ns / 100ps

module cartridge_bank_mapper_tb;
  import cbm_pkg::*;

  // cartridge type ranges
  localparam logic [7:0] CART_MBC1_FIRST = 8'h01;
  localparam logic [7:0] CART_MBC1_LAST  = 8'h03;
  localparam logic [7:0] CART_MBC3_FIRST = 8'h0F;
  localparam logic [7:0] CART_MBC3_LAST  = 8'h13;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_WORDS   = 104;
  localparam int NUM_PHASES    = 7;

  // settings visited by the random phases, extremes included
  localparam logic [7:0] PHASE_CART [NUM_PHASES] =
    '{8'h13, 8'h0F, 8'h02, 8'h00, 8'h11, 8'h03, 8'hFF};
  localparam logic [7:0] PHASE_ROM_LOG2 [NUM_PHASES] =
    '{8'd15, 8'd18, 8'd21, 8'd20, 8'd31, 8'd16, 8'd22};

  // tracks bank controller state and the results it owes
  class bank_state_tracker;
    logic [7:0]               cart_type;
    logic [4:0]               rom_log2;
    logic [ROM_BANK_BITS-1:0] rom_bank;
    logic [1:0]               ram_bank;
    logic                     ram_on;
    logic                     bank_mode;
    logic [7:0]               cart_ram [RAM_BYTES];
    rsp_word_t                owed_rsp [$];
    int errors;
    int checked;
    int rom_reads;
    int ram_hits;
    int flushes;

    function new();
      cart_type = 8'h00;
      rom_log2  = 5'd21;
      rom_bank  = ROM_BANK_BITS'(1);
      ram_bank  = 2'd0;
      ram_on    = 1'b0;
      bank_mode = 1'b0;
      foreach (cart_ram[i]) cart_ram[i] = 8'h00;
      errors = 0;
      checked = 0;
      rom_reads = 0;
      ram_hits = 0;
      flushes = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
      if (idx == CFG_CART_TYPE) cart_type = data;
      else if (idx == CFG_ROM_SIZE) rom_log2 = data[4:0];
    endfunction

    function bit is_mbc1();
      return cart_type >= CART_MBC1_FIRST && cart_type <= CART_MBC1_LAST;
    endfunction

    function bit is_mbc3();
      return cart_type >= CART_MBC3_FIRST && cart_type <= CART_MBC3_LAST;
    endfunction

    // wrap to the rom size, sizes past 2 MiB act as 2 MiB
    function logic [ROM_AW-1:0] rom_wrap(int unsigned a);
      int unsigned lg;
      lg = (rom_log2 > 5'd21) ? 32'd21 : 32'(rom_log2);
      return ROM_AW'(a & ((32'd1 << lg) - 32'd1));
    endfunction

    function logic [RAM_AW-1:0] ram_slot(logic [15:0] addr);
      return RAM_AW'(((32'(addr) - 32'hA000) + 32'(ram_bank) * 32'h2000) % RAM_BYTES);
    endfunction

    // one bus access: result word plus register and ram updates
    function rsp_word_t map_access(req_word_t w);
      rsp_word_t r;
      logic      en;
      logic [4:0] lo5;
      logic [6:0] lo7;
      r = '0;
      if (w.func == FUNC_READ) begin
        case (w.address[15:13])
          WIN_RAM_ENABLE, WIN_ROM_BANK: begin
            r.rom_read = 1'b1;
            r.rom_address = rom_wrap(32'(w.address));
          end
          WIN_RAM_BANK, WIN_BANK_MODE: begin
            r.rom_read = 1'b1;
            r.rom_address = rom_wrap((32'(w.address) - 32'h4000) + 32'(rom_bank) * 32'h4000);
          end
          WIN_CART_RAM: r.read_data = ram_on ? cart_ram[ram_slot(w.address)] : OPEN_BUS;
          default: r.read_data = OPEN_BUS;
        endcase
      end else begin
        case (w.address[15:13])
          WIN_RAM_ENABLE: begin
            en = (w.value[3:0] == RAM_ENABLE_KEY);
            if (ram_on && !en) r.flush_request = 1'b1;
            ram_on = en;
          end
          WIN_ROM_BANK: begin
            if (is_mbc1()) begin
              lo5 = w.value[4:0];
              if (lo5 == 5'd0) lo5 = 5'd1;
              rom_bank = {rom_bank[ROM_BANK_BITS-1:5], lo5};
            end else if (is_mbc3()) begin
              lo7 = w.value[6:0];
              if (lo7 == 7'd0) lo7 = 7'd1;
              rom_bank = lo7;
            end
          end
          WIN_RAM_BANK: begin
            if (is_mbc1()) begin
              if (bank_mode) ram_bank = w.value[1:0];
              else rom_bank = {w.value[1:0], rom_bank[4:0]};
            end else if (is_mbc3()) begin
              // clock register selects leave the ram bank alone
              if (w.value <= 8'd3) ram_bank = w.value[1:0];
            end
          end
          WIN_BANK_MODE: begin
            if (is_mbc1()) bank_mode = w.value[0];
          end
          WIN_CART_RAM: begin
            if (ram_on) cart_ram[ram_slot(w.address)] = w.value;
          end
          default: ;
        endcase
      end
      return r;
    endfunction

    function void accept_access(req_word_t w);
      rsp_word_t r;
      r = map_access(w);
      if (r.rom_read) rom_reads++;
      if (r.flush_request) flushes++;
      if (w.address[15:13] == WIN_CART_RAM && ram_on) ram_hits++;
      owed_rsp.push_back(r);
    endfunction

    function void compare_rsp(rsp_word_t got);
      rsp_word_t exp_w;
      if (owed_rsp.size() == 0) begin
        $error("result word with nothing outstanding: %h", got);
        errors++;
        return;
      end
      exp_w = owed_rsp.pop_front();
      checked++;
      if (got.read_data !== exp_w.read_data) begin
        $error("read_data expected %h got %h", exp_w.read_data, got.read_data);
        errors++;
      end
      if (got.rom_read !== exp_w.rom_read) begin
        $error("rom_read expected %b got %b", exp_w.rom_read, got.rom_read);
        errors++;
      end
      if (got.rom_address !== exp_w.rom_address) begin
        $error("rom_address expected %h got %h", exp_w.rom_address, got.rom_address);
        errors++;
      end
      if (got.flush_request !== exp_w.flush_request) begin
        $error("flush_request expected %b got %b", exp_w.flush_request, got.flush_request);
        errors++;
      end
    endfunction

    function int pending();
      return owed_rsp.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 req_valid;
  logic                 req_ready;
  req_word_t            req;
  logic                 rsp_valid;
  logic                 rsp_ready;
  rsp_word_t            rsp;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  bank_state_tracker tracker = new();
  req_word_t access_queue [$];
  bit        hold_request;
  int        cycle_count;
  int        words_sent;

  cartridge_bank_mapper uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d words outstanding", cycle_count, tracker.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: stall pattern plus one long hold on request
  initial begin : rsp_stall
    int stall_pct;
    int pattern_left;
    int hold_left;
    stall_pct = 0;
    pattern_left = 0;
    hold_left = 0;
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 60;
            default: stall_pct = 90;
          endcase
          pattern_left = $urandom_range(16, 96);
        end
        pattern_left--;
        rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // check each accepted result word
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) tracker.compare_rsp(rsp);
  end

  function automatic req_word_t make_access(logic func, logic [15:0] addr, logic [7:0] val);
    req_word_t w;
    w.func = func;
    w.address = addr;
    w.value = val;
    return w;
  endfunction

  // mostly well-formed register, rom and ram traffic, some raw noise
  function automatic req_word_t random_access();
    req_word_t w;
    int pick;
    logic [12:0] offset;
    pick = $urandom_range(0, 99);
    w.func = FUNC_WRITE;
    w.value = 8'($urandom());
    offset = ($urandom_range(0, 1) == 0) ? 13'($urandom_range(0, 15)) : 13'($urandom());
    if (pick < 10) begin
      w.address = {WIN_RAM_ENABLE, 13'($urandom())};
      if ($urandom_range(0, 9) < 7) w.value[3:0] = RAM_ENABLE_KEY;
    end else if (pick < 20) begin
      w.address = {WIN_ROM_BANK, 13'($urandom())};
      case ($urandom_range(0, 4))
        0: w.value = w.value & 8'h80;
        1: w.value = w.value & 8'hE0;
        default: ;
      endcase
    end else if (pick < 28) begin
      w.address = {WIN_RAM_BANK, 13'($urandom())};
      if ($urandom_range(0, 1) == 0) w.value = 8'($urandom_range(0, 3));
    end else if (pick < 34) begin
      w.address = {WIN_BANK_MODE, 13'($urandom())};
    end else if (pick < 50) begin
      w.func = FUNC_READ;
      w.address = 16'($urandom_range(0, 16'h7FFF));
    end else if (pick < 75) begin
      w.address = {WIN_CART_RAM, offset};
    end else if (pick < 93) begin
      w.func = FUNC_READ;
      w.address = {WIN_CART_RAM, offset};
    end else begin
      w.func = 1'($urandom());
      w.address = 16'($urandom());
    end
    return w;
  endfunction

  // offer queued words in bursts with random gaps
  task automatic play_accesses();
    int burst_left;
    int gap;
    burst_left = 0;
    while (access_queue.size() > 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          @(negedge clk);
          req_valid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
      @(negedge clk);
      req_valid <= 1'b1;
      req <= access_queue[0];
      do @(posedge clk); while (!req_ready);
      tracker.accept_access(access_queue.pop_front());
      words_sent++;
      burst_left--;
    end
    @(negedge clk);
    req_valid <= 1'b0;
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every owed result word is back, then let the pipe settle
  task automatic drain();
    while (tracker.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // main sequence
  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_CART_TYPE;
    cfg_data = 8'h00;
    hold_request = 1'b0;
    words_sent = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed pass in mbc1 mode at full rom size
    write_register(CFG_CART_TYPE, CART_MBC1_FIRST);
    write_register(CFG_ROM_SIZE, 8'd21);
    access_queue.push_back(make_access(FUNC_READ, 16'h0000, 8'h00));
    access_queue.push_back(make_access(FUNC_READ, 16'h3FFF, 8'hFF));
    access_queue.push_back(make_access(FUNC_READ, 16'h4000, 8'h00));
    access_queue.push_back(make_access(FUNC_READ, 16'h7FFF, 8'h00));
    access_queue.push_back(make_access(FUNC_READ, 16'hA000, 8'h00));
    access_queue.push_back(make_access(FUNC_WRITE, 16'hA000, 8'h33));
    access_queue.push_back(make_access(FUNC_WRITE, 16'h0000, 8'h0A));
    access_queue.push_back(make_access(FUNC_READ, 16'hA000, 8'h00));
    access_queue.push_back(make_access(FUNC_WRITE, 16'hA000, 8'h5A));
    access_queue.push_back(make_access(FUNC_WRITE, 16'hBFFF, 8'hFF));
    access_queue.push_back(make_access(FUNC_READ, 16'hA000, 8'h00));
    access_queue.push_back(make_access(FUNC_READ, 16'hBFFF, 8'h00));
    access_queue.push_back(make_access(FUNC_WRITE, 16'h2000, 8'h00));
    access_queue.push_back(make_access(FUNC_READ, 16'h4000, 8'h00));
    access_queue.push_back(make_access(FUNC_WRITE, 16'h3FFF, 8'hFF));
    access_queue.push_back(make_access(FUNC_WRITE, 16'h4000, 8'h03));
    access_queue.push_back(make_access(FUNC_READ, 16'h7FFF, 8'h00));
    access_queue.push_back(make_access(FUNC_WRITE, 16'h6000, 8'h01));
    access_queue.push_back(make_access(FUNC_WRITE, 16'h5FFF, 8'h03));
    access_queue.push_back(make_access(FUNC_WRITE, 16'hBFFF, 8'h81));
    access_queue.push_back(make_access(FUNC_READ, 16'hBFFF, 8'h00));
    access_queue.push_back(make_access(FUNC_READ, 16'h8000, 8'h00));
    access_queue.push_back(make_access(FUNC_READ, 16'hFFFF, 8'h00));
    access_queue.push_back(make_access(FUNC_WRITE, 16'hC000, 8'h55));
    access_queue.push_back(make_access(FUNC_WRITE, 16'h1FFF, 8'hF0));
    access_queue.push_back(make_access(FUNC_WRITE, 16'h0000, 8'h00));
    access_queue.push_back(make_access(FUNC_READ, 16'hBFFF, 8'h00));
    play_accesses();
    drain();

    // random phases, one setting each
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_register(CFG_CART_TYPE, PHASE_CART[p]);
      write_register(CFG_ROM_SIZE, PHASE_ROM_LOG2[p]);
      // long result hold while the sender keeps offering
      if (p == 2) hold_request = 1'b1;
      repeat (PHASE_WORDS) access_queue.push_back(random_access());
      play_accesses();
      drain();
    end

    $display("covered %0d bus words over %0d register settings: %0d rom reads,",
             words_sent, NUM_PHASES + 1, tracker.rom_reads);
    $display("%0d enabled ram accesses, %0d flushes, %0d result words compared",
             tracker.ram_hits, tracker.flushes, tracker.checked);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
